// ----- sv/bvic_pkg.sv -----
// Shared types, codes and a width-mask helper function for the invertibility checker.
package bvic_pkg;

    localparam int DATA_W        = 64;
    localparam int MAX_WIDTH_DEF = 64;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_AND    = 4'd1;
    localparam logic [3:0] OP_CONCAT = 4'd2;
    localparam logic [3:0] OP_EQ     = 4'd3;
    localparam logic [3:0] OP_MUL    = 4'd4;
    localparam logic [3:0] OP_SLL    = 4'd5;
    localparam logic [3:0] OP_SRA    = 4'd6;
    localparam logic [3:0] OP_SRL    = 4'd7;
    localparam logic [3:0] OP_ULT    = 4'd8;
    localparam logic [3:0] OP_UDIV   = 4'd9;
    localparam logic [3:0] OP_UREM   = 4'd10;
    localparam logic [3:0] OP_SLICE  = 4'd11;

    typedef enum logic [1:0] {
        SH_SLL,
        SH_SRL,
        SH_SRA
    } t_shift_kind;

    typedef enum logic {
        MD_MUL,
        MD_DIV
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT,
        ST_LOOP,
        ST_ARITH_GO,
        ST_ARITH_WAIT
    } t_state;

    // Ones in the low w bits; w of 64 or more gives all ones.
    function automatic logic [DATA_W-1:0] width_mask(input logic [6:0] w);
        logic [DATA_W-1:0] res;
        if (w >= 7'(DATA_W)) begin
            res = '1;
        end else begin
            res = (DATA_W'(1) << w) - DATA_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- sv/bvic_shift.sv -----
// Shared width-aware shifter: logical left, logical right and arithmetic right.
module bvic_shift (
    input  bvic_pkg::t_shift_kind         i_kind,
    input  logic [bvic_pkg::DATA_W-1:0]   i_value,
    input  logic [bvic_pkg::DATA_W-1:0]   i_amount,
    input  logic [6:0]                    i_width,
    output logic [bvic_pkg::DATA_W-1:0]   o_result
);
    import bvic_pkg::*;

    logic [DATA_W-1:0] w_mask;
    logic [DATA_W-1:0] w_vm;
    logic              w_big;
    logic              w_neg;
    logic [5:0]        w_amt;

    assign w_mask = width_mask(i_width);
    assign w_vm   = i_value & w_mask;
    assign w_big  = (|i_amount[DATA_W-1:7]) || (i_amount[6:0] >= i_width);
    assign w_neg  = w_vm[6'(i_width - 7'd1)];
    assign w_amt  = i_amount[5:0];

    always_comb begin
        case (i_kind)
            SH_SLL: begin
                o_result = w_big ? '0 : ((w_vm << w_amt) & w_mask);
            end
            SH_SRL: begin
                o_result = w_big ? '0 : (w_vm >> w_amt);
            end
            SH_SRA: begin
                if (w_big) begin
                    o_result = w_neg ? w_mask : '0;
                end else begin
                    o_result = (w_vm >> w_amt) | (w_neg ? (w_mask & ~(w_mask >> w_amt)) : '0);
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

// ----- sv/bvic_muldiv.sv -----
// Bit-serial multiply (low half) and restoring divide, one bit per cycle.
module bvic_muldiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bvic_pkg::t_md_req            i_req,
    input  logic [bvic_pkg::DATA_W-1:0]  i_a,
    input  logic [bvic_pkg::DATA_W-1:0]  i_b,
    output logic                         o_done,
    output logic [bvic_pkg::DATA_W-1:0]  o_res
);
    import bvic_pkg::*;

    logic              r_run,  n_run;
    logic [6:0]        r_cnt,  n_cnt;
    t_md_op            r_op,   n_op;
    logic [DATA_W-1:0] r_a,    n_a;
    logic [DATA_W-1:0] r_b,    n_b;
    logic [DATA_W-1:0] r_acc,  n_acc;
    logic [DATA_W-1:0] r_q,    n_q;
    logic              r_done, n_done;
    logic [DATA_W:0]   w_rem2;
    logic              w_ge;

    assign w_rem2 = {r_acc, r_a[DATA_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_b};

    always_comb begin
        n_run  = r_run;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_q    = r_q;
        n_done = 1'b0;
        if (i_req.start) begin
            n_run = 1'b1;
            n_cnt = 7'(DATA_W);
            n_op  = i_req.op;
            n_a   = i_a;
            n_b   = i_b;
            n_acc = '0;
            n_q   = '0;
        end else if (r_run) begin
            if (r_op == MD_MUL) begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_b = r_b >> 1;
            end else begin
                // Subtract the divisor when the partial remainder covers it.
                n_acc = w_ge ? DATA_W'(w_rem2 - {1'b0, r_b}) : w_rem2[DATA_W-1:0];
                n_q   = {r_q[DATA_W-2:0], w_ge};
            end
            n_a   = r_a << 1;
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_res  = (r_op == MD_MUL) ? r_acc : r_q;

`ifndef ASSERT_OFF
    a_no_start_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_run) else $error("muldiv started while running");
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run)) else $error("muldiv done without a run");
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_cnt != 7'd0) else $error("muldiv running with empty count");
`endif

endmodule

// ----- sv/bitvector_invertibility_check.sv -----
// Top level: query registers, sequencer and shared shift and multiply/divide units.
//
// One query is taken when start is high and busy is low; exactly one result follows as a
// one-cycle pulse on o_done with o_invertible, and the receiver cannot stall it. Add, and,
// eq, mul, ult, urem, slice, concat with t no wider than s, sra with s at or above the
// width, srl, sra and udiv with const_aware set, and all stub cases are decided in the
// evaluate state. Concat with t wider than s and shifts with s as amount go on to the
// shift state. Shifts with x as amount step the shifter once per candidate amount, up to
// width_s + 1 candidate amounts. udiv runs two passes of the bit-serial multiply/divide
// unit; that unit sets the worst case. busy stays high from the transfer until the result
// pulse.
module bitvector_invertibility_check #(
    parameter int MAX_WIDTH = bvic_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   i_operation,
    input  logic                         i_const_aware,
    input  logic                         i_x_position,
    input  logic [6:0]                   i_width_s,
    input  logic [6:0]                   i_width_t,
    input  logic [bvic_pkg::DATA_W-1:0]  i_s_value,
    input  logic [bvic_pkg::DATA_W-1:0]  i_t_value,
    input  logic [bvic_pkg::DATA_W-1:0]  i_x_low,
    input  logic [bvic_pkg::DATA_W-1:0]  i_x_high,
    output logic                         o_done,
    output logic                         o_invertible
);
    import bvic_pkg::*;

    t_state            r_state, n_state;
    logic [3:0]        r_op;
    logic              r_ca, r_pos;
    logic [6:0]        r_ws, r_wt;
    logic [DATA_W-1:0] r_s, r_traw, r_lo, r_hi;
    logic [DATA_W-1:0] r_x,   n_x;
    logic              r_ok,  n_ok;
    logic [1:0]        r_step, n_step;
    logic [6:0]        r_i,   n_i;
    logic              r_done, n_done;
    logic              r_inv,  n_inv;

    logic              w_accept;
    logic [6:0]        w_ws_c, w_wt_c;
    logic [DATA_W-1:0] m, mt, mx, s_m, t_m, tf, lo_m, hi_m, lo_x, hi_x;
    logic [6:0]        wx;
    logic              tb;

    t_shift_kind       sh_kind;
    logic [DATA_W-1:0] sh_v, sh_amt, sh_res;
    logic [6:0]        sh_w;

    t_md_req           md_req;
    logic [DATA_W-1:0] md_a, md_b, md_res;
    logic              md_done;

    logic              d_fin, d_val;
    t_state            d_next;
    logic              chk, last, fits;
    logic [DATA_W-1:0] d_diff, k_and, q_div, dvsr;

    assign w_accept = start && !busy;
    assign w_ws_c = (i_width_s == 7'd0) ? 7'd1 :
                    (i_width_s > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : i_width_s;
    assign w_wt_c = (i_width_t == 7'd0) ? 7'd1 :
                    (i_width_t > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : i_width_t;

    assign m    = width_mask(r_ws);
    assign mt   = width_mask(r_wt);
    assign wx   = r_wt - r_ws;
    assign mx   = width_mask(wx);
    assign s_m  = r_s & m;
    assign tf   = r_traw & mt;
    assign t_m  = tf & m;
    assign tb   = r_traw[0];
    assign lo_m = r_lo & m;
    assign hi_m = r_hi & m;
    assign lo_x = r_lo & mx;
    assign hi_x = r_hi & mx;

    bvic_shift u_shift (
        .i_kind   (sh_kind),
        .i_value  (sh_v),
        .i_amount (sh_amt),
        .i_width  (sh_w),
        .o_result (sh_res)
    );

    bvic_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (md_a),
        .i_b     (md_b),
        .o_done  (md_done),
        .o_res   (md_res)
    );

    // Shifter and multiply/divide operand selection.
    always_comb begin
        sh_kind = SH_SLL;
        sh_v    = '0;
        sh_amt  = s_m;
        sh_w    = r_ws;
        if (r_state == ST_SHIFT) begin
            case (r_op)
                OP_CONCAT: begin
                    sh_kind = SH_SRL;
                    sh_v    = tf;
                    sh_amt  = DATA_W'(r_pos ? wx : r_ws);
                    sh_w    = 7'(DATA_W);
                end
                OP_SLL: begin
                    case (r_step)
                        2'd0: begin
                            sh_kind = SH_SRL;
                            sh_v    = t_m;
                        end
                        2'd1: sh_v = r_x;
                        2'd2: sh_v = hi_m;
                        default: sh_v = lo_m;
                    endcase
                end
                OP_SRA, OP_SRL: begin
                    if (r_step == 2'd0) begin
                        sh_v = t_m;
                    end else begin
                        sh_kind = (r_op == OP_SRA) ? SH_SRA : SH_SRL;
                        sh_v    = r_x;
                    end
                end
                default: sh_v = '0;
            endcase
        end else if (r_state == ST_LOOP) begin
            sh_v    = s_m;
            sh_amt  = DATA_W'(r_i);
            sh_kind = (r_op == OP_SRA) ? SH_SRA : (r_op == OP_SRL) ? SH_SRL : SH_SLL;
        end
    end

    always_comb begin
        md_req.start = (r_state == ST_ARITH_GO);
        md_req.op    = MD_DIV;
        md_a         = s_m;
        md_b         = r_x;
        if (!r_pos) begin
            if (r_step == 2'd0) begin
                md_req.op = MD_MUL;
                md_b      = t_m;
            end else begin
                md_a = r_x;
                md_b = s_m;
            end
        end else if (r_step == 2'd0) begin
            md_b = t_m;
        end
    end

    assign fits   = (lo_m[DATA_W-1:7] == '0) && ((r_i | lo_m[6:0]) == r_i)
                    && ((DATA_W'(r_i) & hi_m) == DATA_W'(r_i));
    assign d_diff = (t_m - s_m) & m;
    assign k_and  = ~(lo_m ^ hi_m) & m;
    assign dvsr   = r_pos ? ((r_step == 2'd0) ? t_m : r_x) : s_m;
    assign q_div  = (dvsr == '0) ? m : md_res;

    // Decide: finish with a value, or move to the next phase.
    always_comb begin
        d_fin  = 1'b0;
        d_val  = 1'b0;
        d_next = r_state;
        chk    = 1'b1;
        last   = 1'b0;
        case (r_state)
            ST_EVAL: begin
                d_fin = 1'b1;
                case (r_op)
                    OP_ADD:  d_val = !r_ca || (((d_diff & hi_m) | lo_m) == d_diff);
                    OP_AND:  d_val = ((t_m & s_m) == t_m)
                                     && (!r_ca || ((s_m & hi_m & k_and) == (t_m & k_and)));
                    OP_CONCAT: begin
                        if (r_wt > r_ws) begin
                            d_fin  = 1'b0;
                            d_next = ST_SHIFT;
                        end
                    end
                    OP_EQ: begin
                        if (!r_ca) begin
                            d_val = 1'b1;
                        end else if (!tb) begin
                            d_val = (hi_m != lo_m) || (hi_m != s_m);
                        end else begin
                            d_val = ((s_m & hi_m) | lo_m) == s_m;
                        end
                    end
                    OP_MUL:  d_val = r_ca || (((((~s_m) + DATA_W'(1)) | s_m) & m & t_m) == t_m);
                    OP_SLL: begin
                        d_fin  = 1'b0;
                        d_next = r_pos ? ST_LOOP : ST_SHIFT;
                    end
                    OP_SRA: begin
                        if (r_ca) begin
                            d_val = 1'b1;
                        end else if (r_pos) begin
                            d_fin  = 1'b0;
                            d_next = ST_LOOP;
                        end else if (s_m < DATA_W'(r_ws)) begin
                            d_fin  = 1'b0;
                            d_next = ST_SHIFT;
                        end else begin
                            d_val = (t_m == m) || (t_m == '0);
                        end
                    end
                    OP_SRL: begin
                        if (r_ca) begin
                            d_val = 1'b1;
                        end else begin
                            d_fin  = 1'b0;
                            d_next = r_pos ? ST_LOOP : ST_SHIFT;
                        end
                    end
                    OP_ULT: begin
                        if (!r_ca) begin
                            d_val = !tb || (!r_pos ? (s_m != '0) : (s_m != m));
                        end else if (!r_pos) begin
                            d_val = tb ? ((s_m != '0) && (lo_m < s_m)) : (hi_m >= s_m);
                        end else begin
                            d_val = tb ? ((s_m != m) && (hi_m > s_m)) : (lo_m <= s_m);
                        end
                    end
                    OP_UDIV: begin
                        if (r_ca) begin
                            d_val = 1'b1;
                        end else begin
                            d_fin  = 1'b0;
                            d_next = ST_ARITH_GO;
                        end
                    end
                    OP_UREM: begin
                        if (r_ca) begin
                            d_val = 1'b1;
                        end else if (!r_pos) begin
                            d_val = t_m <= (~((~s_m) + DATA_W'(1)) & m);
                        end else begin
                            d_val = t_m <= (((t_m + t_m - s_m) & s_m) & m);
                        end
                    end
                    OP_SLICE: d_val = 1'b1;
                    default:  d_val = 1'b0;
                endcase
            end
            ST_SHIFT: begin
                case (r_op)
                    OP_CONCAT: begin
                        last = 1'b1;
                        if (!r_pos) begin
                            chk = (s_m == t_m) && (!r_ca || (((sh_res & hi_x) | lo_x) == sh_res));
                        end else begin
                            chk = (s_m == sh_res)
                                  && (!r_ca || ((((tf & mx) & hi_x) | lo_x) == (tf & mx)));
                        end
                    end
                    OP_SLL: begin
                        last = r_ca ? (r_step == 2'd3) : (r_step == 2'd1);
                        case (r_step)
                            2'd0: chk = 1'b1;
                            2'd1: chk = sh_res == t_m;
                            2'd2: chk = (sh_res & t_m) == t_m;
                            default: chk = (sh_res | t_m) == t_m;
                        endcase
                    end
                    default: begin
                        last = r_step == 2'd1;
                        chk  = (r_step == 2'd0) || (sh_res == t_m);
                    end
                endcase
                if (last) begin
                    d_fin = 1'b1;
                    d_val = r_ok && chk;
                end
            end
            ST_LOOP: begin
                if ((sh_res == t_m) && ((r_op != OP_SLL) || !r_ca || fits)) begin
                    d_fin = 1'b1;
                    d_val = 1'b1;
                end else if (r_i == ((r_op == OP_SRA) ? (r_ws - 7'd1) : r_ws)) begin
                    d_fin = 1'b1;
                end
            end
            ST_ARITH_WAIT: begin
                if (md_done) begin
                    if (r_step == 2'd1) begin
                        d_fin = 1'b1;
                        d_val = q_div == t_m;
                    end else begin
                        d_next = ST_ARITH_GO;
                    end
                end
            end
            default: d_fin = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        case (r_state)
            ST_IDLE:     n_state = w_accept ? ST_EVAL : ST_IDLE;
            ST_ARITH_GO: n_state = ST_ARITH_WAIT;
            ST_EVAL, ST_SHIFT, ST_LOOP, ST_ARITH_WAIT: begin
                n_state = d_fin ? ST_IDLE : d_next;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath and result updates.
    always_comb begin
        n_x    = r_x;
        n_ok   = r_ok;
        n_step = r_step;
        n_i    = r_i;
        n_done = d_fin;
        n_inv  = d_fin ? d_val : r_inv;
        case (r_state)
            ST_EVAL: begin
                n_ok   = 1'b1;
                n_step = 2'd0;
                n_i    = 7'd0;
            end
            ST_SHIFT: begin
                // Hold the first shift result for the second pass.
                if (r_step == 2'd0) begin
                    n_x = sh_res;
                end
                n_ok   = r_ok && chk;
                n_step = r_step + 2'd1;
            end
            ST_LOOP: n_i = r_i + 7'd1;
            ST_ARITH_WAIT: begin
                if (md_done && (r_step == 2'd0)) begin
                    n_x    = r_pos ? q_div : (md_res & m);
                    n_step = 2'd1;
                end
            end
            default: n_x = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_inv   <= n_inv;
        end
        if (w_accept) begin
            r_op   <= i_operation;
            r_ca   <= i_const_aware;
            r_pos  <= i_x_position;
            r_ws   <= w_ws_c;
            r_wt   <= w_wt_c;
            r_s    <= i_s_value;
            r_traw <= i_t_value;
            r_lo   <= i_x_low;
            r_hi   <= i_x_high;
        end
        r_x    <= n_x;
        r_ok   <= n_ok;
        r_step <= n_step;
        r_i    <= n_i;
    end

    assign busy         = r_state != ST_IDLE;
    assign o_done       = r_done;
    assign o_invertible = r_inv;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transfer did not raise busy");
    a_done_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result without a query in work");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while still busy");
    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOP) |-> (r_i <= r_ws)) else $error("candidate past width");
`endif

endmodule
